// ===== hw/rtl/sliding_window_min_max_top_assert.svh =====
// Assertion macros for the sliding window min/max block.
// Each check runs on the rising clock edge and is off while reset is high.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SWMM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define SWMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`else

`define SWMM_ASSERT(label, prop, msg)

`define SWMM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/swmm_pkg.sv =====
`timescale 1ns / 1ps

package swmm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int POS_BITS    = 16;
   localparam int LEN_BITS    = 7;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(3);

   // register index, taken from paddr[2]
   localparam logic REG_WINDOW_LEN = 1'b0;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          restart;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] window_min;
      logic signed [SAMPLE_BITS-1:0] window_max;
   } rsp_type;

   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [POS_BITS-1:0]           pos;
   } swmm_entry_type;

   typedef struct packed {
      logic                          load;
      logic                          clear;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [POS_BITS-1:0]           new_pos;
   } swmm_push_type;

   typedef struct packed {
      logic                          load;
      logic                          shift;
      logic                          clear;
      logic                          is_max;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [POS_BITS-1:0]           new_pos;
   } swmm_ctrl_type;

endpackage

// ===== hw/rtl/swmm_cell.sv =====
`timescale 1ns / 1ps

module swmm_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  swmm_pkg::swmm_ctrl_type ctrl,
   input  swmm_pkg::swmm_entry_type neighbor,
   input  logic                    prev_keep,
   output logic                    keep,
   output swmm_pkg::swmm_entry_type state,
   output swmm_pkg::swmm_entry_type state_in
);

   logic                                   valid_ff;
   logic signed [swmm_pkg::SAMPLE_BITS-1:0] value_ff;
   logic [swmm_pkg::POS_BITS-1:0]          pos_ff;
   swmm_pkg::swmm_entry_type               src;
   logic                                   dominated;

   assign state = '{valid: valid_ff, value: value_ff, pos: pos_ff};

   always_comb begin
      src = ctrl.shift ? neighbor : state;
      if (ctrl.is_max) begin
         dominated = $signed(src.value) <= $signed(ctrl.sample);
      end else begin
         dominated = $signed(src.value) >= $signed(ctrl.sample);
      end
      keep = src.valid && !ctrl.clear && !dominated;
      if (ctrl.load) begin
         if (keep) begin
            state_in = src;
         end else if (prev_keep) begin
            state_in = '{valid: 1'b1, value: ctrl.sample, pos: ctrl.new_pos};
         end else begin
            state_in = '{valid: 1'b0, value: src.value, pos: src.pos};
         end
      end else begin
         state_in = src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= state_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= state_in.value;
      pos_ff   <= state_in.pos;
   end

endmodule

// ===== hw/rtl/swmm_deque.sv =====
`timescale 1ns / 1ps

module swmm_deque (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             is_max,
   input  swmm_pkg::swmm_push_type          push,
   input  logic [swmm_pkg::POS_BITS-1:0]    cur_pos,
   input  logic [swmm_pkg::LEN_BITS-1:0]    len,
   output swmm_pkg::swmm_entry_type         front_in,
   output logic                             drain
);

   swmm_pkg::swmm_entry_type       state    [swmm_pkg::WINDOW_MAX];
   swmm_pkg::swmm_entry_type       state_in [swmm_pkg::WINDOW_MAX];
   logic [swmm_pkg::WINDOW_MAX-1:0] keep;
   swmm_pkg::swmm_ctrl_type        ctrl;
   logic [swmm_pkg::POS_BITS-1:0]  len_wide;
   logic [swmm_pkg::POS_BITS-1:0]  age0;
   logic [swmm_pkg::POS_BITS-1:0]  age1;
   logic                           expired0;
   logic                           expired1;

   assign len_wide = {{(swmm_pkg::POS_BITS - swmm_pkg::LEN_BITS){1'b0}}, len};
   assign age0     = cur_pos - state[0].pos;
   assign age1     = cur_pos - state[1].pos;
   assign expired0 = state[0].valid && (age0 >= len_wide);
   assign expired1 = state[1].valid && (age1 >= len_wide);
   assign drain    = expired1;
   assign front_in = state_in[0];

   assign ctrl = '{load: push.load, shift: expired0, clear: push.clear, is_max: is_max,
                   sample: push.sample, new_pos: push.new_pos};

   for (genvar i = 0; i < swmm_pkg::WINDOW_MAX; i++) begin : g_cell
      swmm_pkg::swmm_entry_type nb;
      logic                     pk;
      if (i == swmm_pkg::WINDOW_MAX - 1) begin : g_last
         assign nb = '0;
      end else begin : g_mid
         assign nb = state[i+1];
      end
      if (i == 0) begin : g_first
         assign pk = 1'b1;
      end else begin : g_rest
         assign pk = keep[i-1];
      end
      swmm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .neighbor  (nb),
         .prev_keep (pk),
         .keep      (keep[i]),
         .state     (state[i]),
         .state_in  (state_in[i])
      );
   end

endmodule

// ===== hw/rtl/sliding_window_min_max_top.sv =====
`timescale 1ns / 1ps
// Channel   Ports                          Moves
// req       req_valid/req_ready/req_data   sample word in (sample, restart)
// rsp       rsp_valid/rsp_ready/rsp_data   result word out (window_min, window_max)
// csr       APB: psel/penable/pwrite/...   window_len at byte address 0
//
// One sample word per cycle while req_ready is high; each result is registered.
// Each deque is a row of 64 cells; pops are parallel compares in the cells.
// After window_len is lowered, expired front entries drain one per cycle,
// with req_ready low until no deque holds two expired entries.
// req_ready also drops while both the output register and the skid slot are full.
// Synchronous reset: deques empty, window_len 3; no clearing pass.

`include "sliding_window_min_max_top_assert.svh"

module sliding_window_min_max_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  swmm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output swmm_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swmm_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [swmm_pkg::DATA_BITS-1:0]     pwdata,
   output logic [swmm_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready
);

   logic [swmm_pkg::LEN_BITS-1:0] len_ff;
   logic [swmm_pkg::LEN_BITS-1:0] len_eff;
   logic [swmm_pkg::POS_BITS-1:0] pos_ff;
   logic [swmm_pkg::POS_BITS-1:0] pos_in;
   logic [swmm_pkg::LEN_BITS-1:0] seen_ff;
   logic [swmm_pkg::LEN_BITS-1:0] seen_in;
   logic [swmm_pkg::LEN_BITS-1:0] seen_base;
   logic                          main_valid_ff;
   logic                          main_valid_in;
   swmm_pkg::rsp_type             main_ff;
   swmm_pkg::rsp_type             main_in;
   logic                          skid_valid_ff;
   logic                          skid_valid_in;
   swmm_pkg::rsp_type             skid_ff;
   swmm_pkg::rsp_type             skid_in;
   logic                          accept;
   logic                          produce;
   logic                          out_fire;
   swmm_pkg::rsp_type             result;
   swmm_pkg::swmm_push_type       push;
   swmm_pkg::swmm_entry_type      min_front;
   swmm_pkg::swmm_entry_type      max_front;
   logic                          min_drain;
   logic                          max_drain;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == swmm_pkg::REG_WINDOW_LEN) ?
                   {{(swmm_pkg::DATA_BITS - swmm_pkg::LEN_BITS){1'b0}}, len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= swmm_pkg::LEN_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[2] == swmm_pkg::REG_WINDOW_LEN) begin
         len_ff <= pwdata[swmm_pkg::LEN_BITS-1:0];
      end
   end

   always_comb begin
      if (len_ff == '0) begin
         len_eff = swmm_pkg::LEN_BITS'(1);
      end else if (len_ff > swmm_pkg::LEN_BITS'(swmm_pkg::WINDOW_MAX)) begin
         len_eff = swmm_pkg::LEN_BITS'(swmm_pkg::WINDOW_MAX);
      end else begin
         len_eff = len_ff;
      end
   end

   assign req_ready = !skid_valid_ff && !min_drain && !max_drain;
   assign accept    = req_valid && req_ready;
   assign out_fire  = rsp_valid && rsp_ready;

   assign push = '{load: accept, clear: req_data.restart, sample: req_data.sample,
                   new_pos: req_data.restart ? '0 : pos_ff};

   swmm_deque u_min (
      .clock    (clock),
      .reset    (reset),
      .is_max   (1'b0),
      .push     (push),
      .cur_pos  (pos_ff),
      .len      (len_eff),
      .front_in (min_front),
      .drain    (min_drain)
   );

   swmm_deque u_max (
      .clock    (clock),
      .reset    (reset),
      .is_max   (1'b1),
      .push     (push),
      .cur_pos  (pos_ff),
      .len      (len_eff),
      .front_in (max_front),
      .drain    (max_drain)
   );

   always_comb begin
      seen_base = req_data.restart ? '0 : seen_ff;
      seen_in   = (seen_base < len_eff) ? seen_base + swmm_pkg::LEN_BITS'(1) : seen_base;
      produce   = accept && (seen_in >= len_eff);
      pos_in    = push.new_pos + swmm_pkg::POS_BITS'(1);
      result    = '{window_min: min_front.value, window_max: max_front.value};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seen_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
   end

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = produce;
            main_in       = result;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   `SWMM_ASSERT(a_skid_behind_main, skid_valid_ff |-> main_valid_ff, "skid word without output word")
   `SWMM_ASSERT(a_min_not_above_max, main_valid_ff |-> ($signed(main_ff.window_min) <= $signed(main_ff.window_max)), "window min above window max")
   `SWMM_ASSERT_NEXT(a_restart_pos, accept && req_data.restart, pos_ff == swmm_pkg::POS_BITS'(1), "position not restarted")
   `SWMM_ASSERT(a_seen_bounded, seen_ff <= swmm_pkg::LEN_BITS'(swmm_pkg::WINDOW_MAX), "sample count past window limit")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic signed [swmm_pkg::SAMPLE_BITS-1:0] value;
      logic [swmm_pkg::POS_BITS-1:0]           pos;
   } slot_type;

   class window_scoreboard;
      logic [swmm_pkg::LEN_BITS-1:0] window_len = swmm_pkg::LEN_RESET;
      slot_type                      rising_q[$];
      slot_type                      falling_q[$];
      logic [swmm_pkg::POS_BITS-1:0] next_pos = '0;
      int unsigned                   filled = 0;
      swmm_pkg::rsp_type             expected_q[$];
      int unsigned                   errors = 0;
      int unsigned                   results = 0;

      function void flag(string what, logic [31:0] exp, logic [31:0] got);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, exp, got);
      endfunction

      function int unsigned span();
         if (window_len == 0) return 1;
         if (window_len > swmm_pkg::WINDOW_MAX) return swmm_pkg::WINDOW_MAX;
         return window_len;
      endfunction

      function void push_slot(ref slot_type q[$], input bit keep_max,
                              input logic signed [swmm_pkg::SAMPLE_BITS-1:0] v,
                              input int unsigned len);
         logic [swmm_pkg::POS_BITS-1:0] age;
         slot_type                      s;
         while (q.size() > 0) begin
            age = next_pos - q[0].pos;
            if (age < len) break;
            void'(q.pop_front());
         end
         while (q.size() > 0) begin
            if (keep_max ? (q[$].value > v) : (q[$].value < v)) break;
            void'(q.pop_back());
         end
         s.value = v;
         s.pos   = next_pos;
         q.push_back(s);
      endfunction

      function void note_sample(swmm_pkg::req_type w);
         int unsigned       len;
         swmm_pkg::rsp_type r;
         len = span();
         if (w.restart) begin
            rising_q.delete();
            falling_q.delete();
            next_pos = '0;
            filled   = 0;
         end
         push_slot(rising_q, 1'b0, w.sample, len);
         push_slot(falling_q, 1'b1, w.sample, len);
         next_pos++;
         if (filled < len) filled++;
         if (filled >= len) begin
            r.window_min = rising_q[0].value;
            r.window_max = falling_q[0].value;
            expected_q.push_back(r);
         end
      endfunction

      function void check_result(swmm_pkg::rsp_type got);
         swmm_pkg::rsp_type exp;
         if (expected_q.size() == 0) begin
            flag("unexpected word (min shown)", '0, got.window_min);
            return;
         end
         exp = expected_q.pop_front();
         results++;
         if (got.window_min !== exp.window_min)
            flag("window_min", exp.window_min, got.window_min);
         if (got.window_max !== exp.window_max)
            flag("window_max", exp.window_max, got.window_max);
      endfunction
   endclass

   localparam logic signed [swmm_pkg::SAMPLE_BITS-1:0] OPENING [16] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 5, 5, 5,
      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
      10, 20, 30, 40
   };
   localparam logic [swmm_pkg::LEN_BITS-1:0] PLAN [12] = '{
      64, 127, 2, 65, 5, 0, 17, 1, 100, 7, 40, 3
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid;
   logic                           req_ready;
   swmm_pkg::req_type              req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   swmm_pkg::rsp_type              rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [swmm_pkg::ADDR_BITS-1:0] paddr;
   logic [swmm_pkg::DATA_BITS-1:0] pwdata;
   logic [swmm_pkg::DATA_BITS-1:0] prdata;
   logic                           pready;

   bit                                      idle_on = 1'b1;
   int unsigned                             sample_count = 0;
   int unsigned                             setting_count = 0;
   logic signed [swmm_pkg::SAMPLE_BITS-1:0] ramp_val = 0;
   int                                      ramp_step = 1;
   window_scoreboard                        sb = new;

   sliding_window_min_max_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic signed [swmm_pkg::SAMPLE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5: return $urandom_range(0, 6) - 3;
         6: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 0;
               default: return -1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 15) == 0) ramp_step = int'($urandom_range(0, 6)) - 3;
            ramp_val += ramp_step;
            return ramp_val;
         end
      endcase
   endfunction

   task automatic csr_cycle(input bit wr, input logic [swmm_pkg::DATA_BITS-1:0] wdata,
                            output logic [swmm_pkg::DATA_BITS-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= swmm_pkg::ADDR_BITS'(4 * swmm_pkg::REG_WINDOW_LEN);
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      // let a trailing sample with no result settle
      repeat (8) @(posedge clock);
   endtask

   task automatic set_window(logic [swmm_pkg::LEN_BITS-1:0] len);
      logic [swmm_pkg::DATA_BITS-1:0] rd;
      wait_idle();
      csr_cycle(1'b1, ($urandom() & 32'hFFFF_FF80) | swmm_pkg::DATA_BITS'(len), rd);
      sb.window_len = len;
      setting_count++;
      csr_cycle(1'b0, '0, rd);
      if (rd !== swmm_pkg::DATA_BITS'(len))
         sb.flag("window_len readback", swmm_pkg::DATA_BITS'(len), rd);
   endtask

   task automatic send_sample(logic signed [swmm_pkg::SAMPLE_BITS-1:0] v, logic r);
      swmm_pkg::req_type w;
      int                gap;
      w.sample = v;
      w.restart = r;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(w);
      sample_count++;
   endtask

   initial begin : receiver
      int stall;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   initial begin : stimulus
      int unsigned                    count;
      logic [swmm_pkg::DATA_BITS-1:0] rd;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      reset     <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_cycle(1'b0, '0, rd);
      if (rd !== swmm_pkg::DATA_BITS'(swmm_pkg::LEN_RESET))
         sb.flag("window_len reset value", swmm_pkg::DATA_BITS'(swmm_pkg::LEN_RESET), rd);

      foreach (OPENING[i]) send_sample(OPENING[i], 1'b0);
      send_sample(7, 1'b1);
      send_sample(-7, 1'b0);
      send_sample(3, 1'b0);
      set_window(1);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      set_window(0);
      send_sample(-2, 1'b0);
      send_sample(2, 1'b0);

      foreach (PLAN[p]) begin
         set_window(PLAN[p]);
         count = (PLAN[p] >= 32) ? 90 : 25;
         for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_sample(pick_value(),
                        (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0));
         end
      end
      idle_on = 1'b1;

      wait_idle();
      $display("Run covered %0d samples and %0d checked windows over %0d window_len settings,",
               sample_count, sb.results, setting_count);
      $display("with restarts, ties, extreme values and expiry drains after shrinking windows.");
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sliding_window_min_max_top.f =====
+incdir+hw/rtl
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_cell.sv
hw/rtl/swmm_deque.sv
hw/rtl/sliding_window_min_max_top.sv
test/tb.sv
